### sv/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg: shared types for the array list engine
// Request modes, result status codes, cell commands and controller states.
// ----------------------------------------------------------------------------
package ale_pkg;

  typedef enum logic [2:0] {
    MD_GET    = 3'd0,
    MD_SEARCH = 3'd1,
    MD_INSERT = 3'd2,
    MD_REMOVE = 3'd3,
    MD_SORT   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_SORT
  } op_t;

  typedef enum logic {
    CS_IDLE,
    CS_SORT
  } ctl_state_t;

  localparam int PosWidth = 7;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    op_t                 op;
    logic [PosWidth-1:0] pos;
    logic                phase;
  } cmd_t;

endpackage

### sv/ale_cell.sv
// ----------------------------------------------------------------------------
// ale_cell: one slot of the list
// Holds one entry; shifts, places, or compare-exchanges with a neighbor.
// ----------------------------------------------------------------------------
module ale_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 7,
  parameter int IDX        = 0
) (
  input  logic                          clk,
  input  ale_pkg::cmd_t                 cmd,
  input  logic [CNT_W-1:0]              count,
  input  logic signed [DATA_WIDTH-1:0]  value,
  input  logic signed [DATA_WIDTH-1:0]  left_data,
  input  logic signed [DATA_WIDTH-1:0]  right_data,
  output logic signed [DATA_WIDTH-1:0]  data,
  output logic                          hit,
  output logic [DATA_WIDTH-1:0]         sel_data
);
  import ale_pkg::*;

  localparam int CW = (CNT_W > PosWidth) ? CNT_W : PosWidth;
  localparam logic [CW-1:0] MyIdx  = CW'(IDX);
  localparam logic [CW-1:0] NextIdx = CW'(IDX + 1);
  localparam logic          MyPar  = 1'(IDX % 2);

  logic signed [DATA_WIDTH-1:0] entry;
  logic signed [DATA_WIDTH-1:0] entry_next;
  logic [CW-1:0]                pos_w;
  logic [CW-1:0]                cnt_w;

  assign pos_w = CW'(cmd.pos);
  assign cnt_w = CW'(count);

  always_comb begin
    entry_next = entry;
    case (cmd.op)
      OP_INSERT: begin
        if (MyIdx == pos_w) begin
          entry_next = value;
        end else if (MyIdx > pos_w) begin
          entry_next = left_data;
        end
      end
      OP_REMOVE: begin
        if (MyIdx >= pos_w) begin
          entry_next = right_data;
        end
      end
      OP_SORT: begin
        if (MyPar == cmd.phase) begin
          // low side of a pair: keep the smaller
          if (NextIdx < cnt_w && right_data < entry) begin
            entry_next = right_data;
          end
        end else begin
          // high side of a pair: keep the larger
          if (IDX > 0 && MyIdx < cnt_w && left_data > entry) begin
            entry_next = left_data;
          end
        end
      end
      default: entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign data     = entry;
  assign hit      = (entry == value) && (MyIdx < cnt_w);
  assign sel_data = (MyIdx == pos_w) ? entry : '0;

endmodule

### sv/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl: request sequencer and result register
// Decodes requests, drives the cell command, tracks the count, runs sort.
// ----------------------------------------------------------------------------
module ale_ctrl #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           mode,
  input  logic [ale_pkg::PosWidth-1:0]         position,
  input  logic                                 any_hit,
  input  logic [$clog2(CAPACITY)-1:0]          hit_pos,
  input  logic signed [DATA_WIDTH-1:0]         rd_word,
  output ale_pkg::cmd_t                        cmd,
  output logic [$clog2(CAPACITY+1)-1:0]        count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           status,
  output logic [5:0]                           found_position,
  output logic signed [31:0]                   read_value,
  output logic [6:0]                           live_count
);
  import ale_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > PosWidth) ? CNT_W : PosWidth;
  localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

  ctl_state_t        state;
  ctl_state_t        state_next;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  remaining;
  logic [CNT_W-1:0]  remaining_next;
  logic              accept;
  logic              load;
  status_t           res_status;
  logic [5:0]        res_found;
  logic signed [31:0] res_read;
  logic [CW-1:0]     pos_w;
  logic [CW-1:0]     cnt_w;

  assign in_ready = (state == CS_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign pos_w    = CW'(position);
  assign cnt_w    = CW'(count);

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    load           = 1'b0;
    res_status     = ST_MISS;
    res_found      = '0;
    res_read       = '0;
    cmd.op         = OP_HOLD;
    cmd.pos        = position;
    cmd.phase      = remaining[0];
    unique case (state)
      CS_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (mode)
            MD_GET: begin
              if (pos_w < cnt_w) begin
                res_status = ST_OK;
                res_read   = 32'(rd_word);
              end
            end
            MD_SEARCH: begin
              if (any_hit) begin
                res_status = ST_OK;
                res_found  = 6'(hit_pos);
              end
            end
            MD_INSERT: begin
              if (count >= CapCount) begin
                res_status = ST_FULL;
              end else if (pos_w <= cnt_w) begin
                res_status = ST_OK;
                cmd.op     = OP_INSERT;
                count_next = count + 1'b1;
              end
            end
            MD_REMOVE: begin
              if (pos_w < cnt_w) begin
                res_status = ST_OK;
                cmd.op     = OP_REMOVE;
                count_next = count - 1'b1;
              end
            end
            MD_SORT: begin
              res_status = ST_OK;
              if (count > CNT_W'(1)) begin
                // hold the result until the last transposition phase
                load           = 1'b0;
                remaining_next = count;
                state_next     = CS_SORT;
              end
            end
            default: res_status = ST_MISS;
          endcase
        end
      end
      CS_SORT: begin
        cmd.op         = OP_SORT;
        res_status     = ST_OK;
        remaining_next = remaining - 1'b1;
        if (remaining == CNT_W'(1)) begin
          load       = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CS_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status         <= res_status;
      found_position <= res_found;
      read_value     <= res_read;
      live_count     <= 7'(count_next);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CapCount)
    else $error("live count above capacity");

  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MD_INSERT && count == CapCount)
      |=> (out_valid && status == ST_FULL && count == $past(count)))
    else $error("insert into full list not flagged");

  a_sort_count: assert property (@(posedge clk) disable iff (rst)
    (state == CS_SORT) |=> (count == $past(count)))
    else $error("count moved during sort");

  a_sort_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == CS_SORT) |-> !out_valid)
    else $error("result shown while sort still running");
`endif

endmodule

### sv/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine: bounded ordered list of signed words
// A row of CAPACITY cells holds the list; a controller broadcasts commands.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | beat fields
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | mode, position, item_value
//   out     | out_valid / out_ready| status, found_position, read_value,
//           |                      | live_count
//
// Get, search, insert and remove finish in the cycle of acceptance; the result
//   shows in the cycle after; one request per cycle while out_ready is high.
// Sort runs odd-even transposition over the cell row: one phase per cycle,
//   as many phases as live entries (none for fewer than two entries), then
//   the result is shown.
// Reset (rst, synchronous) empties the list; cell contents are left as is.
// in_ready drops during a sort and while an unread result is not drained.
//
module array_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      mode,
  input  logic [ale_pkg::PosWidth-1:0]    position,
  input  logic signed [31:0]              item_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [5:0]                      found_position,
  output logic signed [31:0]              read_value,
  output logic [6:0]                      live_count
);
  import ale_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IW    = $clog2(CAPACITY);

  cmd_t                          cmd;
  logic [CNT_W-1:0]              count;
  logic signed [DATA_WIDTH-1:0]  value;
  logic signed [DATA_WIDTH-1:0]  cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0]         sel_data  [CAPACITY];
  logic [CAPACITY-1:0]           hit;
  logic [CAPACITY-1:0]           first_hit;
  logic                          any_hit;
  logic [IW-1:0]                 hit_pos;
  logic signed [DATA_WIDTH-1:0]  rd_word;

  // Fit the request value to the stored word width (sign-extend or cut).
  assign value = DATA_WIDTH'(item_value);

  // Cell row: each cell sees its two neighbors; zeros stand past the ends.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_data;
    logic signed [DATA_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_left
      assign left_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_right
      assign right_data = cell_data[i+1];
    end

    ale_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .value      (value),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[i]),
      .hit        (hit[i]),
      .sel_data   (sel_data[i])
    );
  end

  // Isolate the lowest matching cell, then encode its position.
  assign first_hit = hit & (~hit + 1'b1);
  assign any_hit   = |hit;

  always_comb begin
    hit_pos = '0;
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        hit_pos = hit_pos | IW'(i);
      end
      // only the addressed cell drives a nonzero word
      rd_word = rd_word | sel_data[i];
    end
  end

  ale_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .position       (position),
    .any_hit        (any_hit),
    .hit_pos        (hit_pos),
    .rd_word        (rd_word),
    .cmd            (cmd),
    .count          (count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_position (found_position),
    .read_value     (read_value),
    .live_count     (live_count)
  );

endmodule
